FILE: hw/rtl/eis_pkg.sv
// eis_pkg: shared types, command and phase codes for the eeprom transfer sequencer
// used by eis_decode, eis_emitter and eeprom_i2c_transfer_sequencer
// no dependencies
package eis_pkg;

  localparam int DEFAULT_PAGE_BYTES = 64;
  localparam int RESULT_SLOTS = 8;
  localparam int SLOT_W = $clog2(RESULT_SLOTS);
  localparam int COUNT_W = $clog2(RESULT_SLOTS + 1);
  localparam int PHASE_W = 3;
  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_POLL  = 2'd2;

  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_RESTART = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_WRITE   = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_ACK     = 3'd5;
  localparam logic [2:0] CMD_NACK    = 3'd6;

  localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WRITE      = 3'd1;
  localparam logic [PHASE_W-1:0] PH_READ       = 3'd2;
  localparam logic [PHASE_W-1:0] PH_POLL_PAGE  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_POLL_FINAL = 3'd4;
  localparam logic [PHASE_W-1:0] PH_HELD       = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic        first;
    logic [15:0] mem_address;
    logic [7:0]  data_byte;
    logic        final_byte;
    logic        acked;
  } item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] byte_value;
    logic       awaiting_response;
    logic       transfer_done;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    result_t [RESULT_SLOTS-1:0] entries;
    logic [COUNT_W-1:0]         count;
    logic [PHASE_W-1:0]         phase;
    logic [15:0]                address;
  } plan_t;

  function automatic result_t make_result(logic [2:0] cmd, logic [7:0] value,
                                          logic wait_resp, logic done);
    result_t r;
    r.command = cmd;
    r.byte_value = (cmd == CMD_WRITE) ? value : 8'd0;
    r.awaiting_response = wait_resp;
    r.transfer_done = done;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

FILE: hw/rtl/eis_decode.sv
// eis_decode: expands one transaction into its list of i2c primitives and next state
// depends on eis_pkg
module eis_decode #(
  parameter int PAGE_BYTES = eis_pkg::DEFAULT_PAGE_BYTES
) (
  input  eis_pkg::item_t                    item,
  input  logic [eis_pkg::PHASE_W-1:0]       phase,
  input  logic [15:0]                       address,
  input  logic [6:0]                        device_address,
  output eis_pkg::plan_t                    plan
);
  import eis_pkg::*;

  // page size must be a power of two
  localparam int PAGE_BITS = $clog2(PAGE_BYTES);

  logic polling;
  logic held;
  logic [7:0] ctrl_wr;
  logic [7:0] ctrl_rd;

  assign polling = (phase == PH_POLL_PAGE) || (phase == PH_POLL_FINAL);
  assign held = (phase == PH_WRITE) || (phase == PH_READ) || (phase == PH_HELD);
  assign ctrl_wr = {device_address, 1'b0};
  assign ctrl_rd = {device_address, 1'b1};

  always_comb begin
    logic [COUNT_W-1:0] n;
    logic [15:0] a;
    logic [PHASE_W-1:0] ph;
    result_t [RESULT_SLOTS-1:0] ents;
    n = '0;
    a = address;
    ph = phase;
    ents = '0;
    if (item.operation == OP_WRITE && !polling && (item.first || phase == PH_WRITE)) begin
      if (item.first) begin
        ents[n[SLOT_W-1:0]] = make_result(held ? CMD_RESTART : CMD_START, 8'd0, 1'b0, 1'b0);
        n = n + 1'b1;
        a = item.mem_address;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, ctrl_wr, 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, a[15:8], 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, a[7:0], 1'b0, 1'b0);
        n = n + 1'b1;
      end
      ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, item.data_byte, 1'b0, 1'b0);
      n = n + 1'b1;
      a = a + 16'd1;
      if (item.final_byte || a[PAGE_BITS-1:0] == '0) begin
        ents[n[SLOT_W-1:0]] = make_result(CMD_STOP, 8'd0, 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_START, 8'd0, 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, ctrl_wr, 1'b1, 1'b0);
        n = n + 1'b1;
        ph = item.final_byte ? PH_POLL_FINAL : PH_POLL_PAGE;
      end else begin
        ph = PH_WRITE;
      end
    end else if (item.operation == OP_READ && !polling &&
                 (item.first || phase == PH_READ)) begin
      if (item.first) begin
        ents[n[SLOT_W-1:0]] = make_result(held ? CMD_RESTART : CMD_START, 8'd0, 1'b0, 1'b0);
        n = n + 1'b1;
        a = item.mem_address;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, ctrl_wr, 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, a[15:8], 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, a[7:0], 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_RESTART, 8'd0, 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, ctrl_rd, 1'b0, 1'b0);
        n = n + 1'b1;
      end
      ents[n[SLOT_W-1:0]] = make_result(CMD_READ, 8'd0, 1'b0, 1'b0);
      n = n + 1'b1;
      a = a + 16'd1;
      if (!item.final_byte) begin
        ents[n[SLOT_W-1:0]] = make_result(CMD_ACK, 8'd0, 1'b0, 1'b0);
        n = n + 1'b1;
        ph = PH_READ;
      end else if (item.first) begin
        ents[n[SLOT_W-1:0]] = make_result(CMD_NACK, 8'd0, 1'b0, 1'b1);
        n = n + 1'b1;
        ph = PH_HELD;
      end else begin
        ents[n[SLOT_W-1:0]] = make_result(CMD_NACK, 8'd0, 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_STOP, 8'd0, 1'b0, 1'b1);
        n = n + 1'b1;
        ph = PH_IDLE;
      end
    end else if (item.operation == OP_POLL && polling) begin
      if (!item.acked) begin
        ents[n[SLOT_W-1:0]] = make_result(CMD_RESTART, 8'd0, 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, ctrl_wr, 1'b1, 1'b0);
        n = n + 1'b1;
      end else if (phase == PH_POLL_PAGE) begin
        ents[n[SLOT_W-1:0]] = make_result(CMD_STOP, 8'd0, 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_START, 8'd0, 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, ctrl_wr, 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, a[15:8], 1'b0, 1'b0);
        n = n + 1'b1;
        ents[n[SLOT_W-1:0]] = make_result(CMD_WRITE, a[7:0], 1'b0, 1'b0);
        n = n + 1'b1;
        ph = PH_WRITE;
      end else begin
        ents[n[SLOT_W-1:0]] = make_result(CMD_STOP, 8'd0, 1'b0, 1'b1);
        n = n + 1'b1;
        ph = PH_IDLE;
      end
    end
    if (n != '0) begin
      ents[SLOT_W'(n - 1'b1)].last_of_run = 1'b1;
    end
    plan.entries = ents;
    plan.count = n;
    plan.phase = ph;
    plan.address = a;
  end

endmodule

FILE: hw/rtl/eis_emitter.sv
// eis_emitter: result register that holds one transaction's primitives and hands them out in order
// depends on eis_pkg
module eis_emitter (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          load,
  input  eis_pkg::result_t [eis_pkg::RESULT_SLOTS-1:0]  entries,
  input  logic [eis_pkg::COUNT_W-1:0]                   count,
  output logic                                          free,
  output logic                                          result_valid,
  input  logic                                          result_stall,
  output eis_pkg::result_t                              result
);
  import eis_pkg::*;

  result_t [RESULT_SLOTS-1:0] slots;
  logic [COUNT_W-1:0] left;
  logic taken;

  assign result_valid = (left != '0);
  assign taken = result_valid && !result_stall;
  assign free = (left == '0) || (taken && left == COUNT_W'(1));
  assign result = slots[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load) begin
      left <= count;
    end else if (taken) begin
      left <= left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= entries;
    end else if (taken) begin
      for (int i = 0; i < RESULT_SLOTS - 1; i++) begin
        slots[i] <= slots[i + 1];
      end
      slots[RESULT_SLOTS-1] <= '0;
    end
  end

endmodule

FILE: hw/rtl/eeprom_i2c_transfer_sequencer.sv
// eeprom_i2c_transfer_sequencer: top level, turns eeprom byte requests into i2c primitives
// depends on eis_pkg, eis_decode, eis_emitter
// usage
//   item channel: item_valid / item_stall / item carry one byte request or poll response
//   result channel: result_valid / result_stall / result carry one i2c primitive each
//   cfg_write / cfg_data set the seven-bit device address; the user must write it only
//   while the block is idle, as the block itself does not enforce this
// timing
//   a transaction is decoded in the cycle it is taken; its first primitive is valid
//   on the next cycle
//   each transaction yields zero to eight primitives, handed out of the result register
//   one per cycle while result_stall is low
//   the next transaction is taken in the cycle the last primitive of the previous one leaves
//   transactions that yield no primitive load nothing, so the item channel stays free
// reset
//   phase returns to idle, address to zero, device address to 80, result register empties
// stall
//   a stalled primitive holds; item_stall rises while earlier primitives remain queued
//   the memory page size must be a power of two
module eeprom_i2c_transfer_sequencer #(
  parameter int PAGE_BYTES = eis_pkg::DEFAULT_PAGE_BYTES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [6:0]       cfg_data,
  input  logic             item_valid,
  output logic             item_stall,
  input  eis_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output eis_pkg::result_t result
);
  import eis_pkg::*;

  logic [6:0] device_address;
  logic [PHASE_W-1:0] phase;
  logic [15:0] address;
  plan_t plan;
  logic free;
  logic accept;

  assign item_stall = !free;
  assign accept = item_valid && free;

  eis_decode #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_decode (
    .item(item),
    .phase(phase),
    .address(address),
    .device_address(device_address),
    .plan(plan)
  );

  eis_emitter u_emitter (
    .clk(clk),
    .rst(rst),
    .load(accept && plan.count != '0),
    .entries(plan.entries),
    .count(plan.count),
    .free(free),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
    end else if (cfg_write) begin
      device_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      address <= '0;
    end else if (accept) begin
      phase <= plan.phase;
      address <= plan.address;
    end
  end

  a_results_follow: assert property (@(posedge clk) disable iff (rst)
    accept && plan.count != '0 |=> result_valid)
    else $error("primitives of a transaction not presented");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("item stalled with empty result register");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_HELD)
    else $error("phase out of range");

  a_wait_only_on_ctrl: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.awaiting_response |-> result.command == CMD_WRITE)
    else $error("poll wait flagged on a non control byte");

endmodule
